>>> rtl/core/ubxfr_pkg.sv
// ----------------------------------------------------------------------------
// ubxfr_pkg
// Types and constants shared by the UBX frame receiver modules.
// ----------------------------------------------------------------------------
package ubxfr_pkg;

  localparam logic [7:0] SyncFirst     = 8'hB5;
  localparam logic [7:0] SyncSecond    = 8'h62;
  localparam int unsigned FrameOverhead = 8;

  localparam logic [1:0] KindData    = 2'd0;
  localparam logic [1:0] KindGood    = 2'd1;
  localparam logic [1:0] KindBadSum  = 2'd2;
  localparam logic [1:0] KindTooLong = 2'd3;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_A    = 9'b010000000,
    PH_CK_B    = 9'b100000000
  } ubxfr_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  class_code;
    logic [7:0]  msg_id;
    logic [7:0]  data_byte;
    logic [8:0]  byte_offset;
    logic [15:0] payload_length;
  } ubxfr_result_t;

endpackage

>>> rtl/core/ubxfr_in_if.sv
// ----------------------------------------------------------------------------
// ubxfr_in_if
// Byte stream channel into the UBX frame receiver.
// ----------------------------------------------------------------------------
interface ubxfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/ubxfr_out_if.sv
// ----------------------------------------------------------------------------
// ubxfr_out_if
// Result channel out of the UBX frame receiver.
// ----------------------------------------------------------------------------
interface ubxfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  class_code;
  logic [7:0]  msg_id;
  logic [7:0]  data_byte;
  logic [8:0]  byte_offset;
  logic [15:0] payload_length;

  modport source (output valid, output kind, output class_code, output msg_id,
                  output data_byte, output byte_offset, output payload_length,
                  input ready);
  modport sink   (input valid, input kind, input class_code, input msg_id,
                  input data_byte, input byte_offset, input payload_length,
                  output ready);
endinterface

>>> rtl/core/ubxfr_parse.sv
// ----------------------------------------------------------------------------
// ubxfr_parse
// Frame parser: sync hunt, header capture, Fletcher-8 sums, verdict.
// ----------------------------------------------------------------------------
module ubxfr_parse #(
  parameter int unsigned BUFFER_BYTES = 512
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    beat_acc,
  input  logic [7:0]              rx_byte,
  output logic                    res_valid,
  output ubxfr_pkg::ubxfr_result_t res
);

  localparam logic [16:0] LengthLimit = 17'(BUFFER_BYTES - ubxfr_pkg::FrameOverhead);

  ubxfr_pkg::ubxfr_phase_t phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  rx_sum_a_r, rx_sum_a_nxt;
  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [8:0]  byte_offset;

  assign sum_a_add = sum_a_r + rx_byte;
  assign sum_b_add = sum_b_r + sum_a_add;

  always_comb begin
    phase_nxt    = phase_r;
    class_nxt    = class_r;
    id_nxt       = id_r;
    length_nxt   = length_r;
    count_nxt    = count_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    rx_sum_a_nxt = rx_sum_a_r;
    res_valid    = 1'b0;
    kind         = ubxfr_pkg::KindData;
    data_byte    = 8'h00;
    byte_offset  = 9'd0;
    if (beat_acc) begin
      case (phase_r)
        ubxfr_pkg::PH_HUNT: begin
          if (rx_byte == ubxfr_pkg::SyncFirst) phase_nxt = ubxfr_pkg::PH_SYNC2;
        end
        ubxfr_pkg::PH_SYNC2: begin
          if (rx_byte == ubxfr_pkg::SyncSecond) begin
            sum_a_nxt = 8'h00;
            sum_b_nxt = 8'h00;
            phase_nxt = ubxfr_pkg::PH_CLASS;
          end else if (rx_byte != ubxfr_pkg::SyncFirst) begin
            phase_nxt = ubxfr_pkg::PH_HUNT;
          end
        end
        ubxfr_pkg::PH_CLASS: begin
          class_nxt = rx_byte;
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          phase_nxt = ubxfr_pkg::PH_ID;
        end
        ubxfr_pkg::PH_ID: begin
          id_nxt    = rx_byte;
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          phase_nxt = ubxfr_pkg::PH_LEN_LO;
        end
        ubxfr_pkg::PH_LEN_LO: begin
          length_nxt = {8'h00, rx_byte};
          sum_a_nxt  = sum_a_add;
          sum_b_nxt  = sum_b_add;
          phase_nxt  = ubxfr_pkg::PH_LEN_HI;
        end
        ubxfr_pkg::PH_LEN_HI: begin
          length_nxt = {rx_byte, length_r[7:0]};
          sum_a_nxt  = sum_a_add;
          sum_b_nxt  = sum_b_add;
          count_nxt  = 16'd0;
          if ({1'b0, length_nxt} > LengthLimit) begin
            res_valid = 1'b1;
            kind      = ubxfr_pkg::KindTooLong;
            phase_nxt = ubxfr_pkg::PH_HUNT;
          end else if (length_nxt == 16'd0) begin
            phase_nxt = ubxfr_pkg::PH_CK_A;
          end else begin
            phase_nxt = ubxfr_pkg::PH_PAYLOAD;
          end
        end
        ubxfr_pkg::PH_PAYLOAD: begin
          sum_a_nxt   = sum_a_add;
          sum_b_nxt   = sum_b_add;
          res_valid   = 1'b1;
          kind        = ubxfr_pkg::KindData;
          data_byte   = rx_byte;
          byte_offset = count_r[8:0];
          count_nxt   = count_r + 16'd1;
          if (count_nxt >= length_r) phase_nxt = ubxfr_pkg::PH_CK_A;
        end
        ubxfr_pkg::PH_CK_A: begin
          rx_sum_a_nxt = rx_byte;
          phase_nxt    = ubxfr_pkg::PH_CK_B;
        end
        ubxfr_pkg::PH_CK_B: begin
          res_valid = 1'b1;
          phase_nxt = ubxfr_pkg::PH_HUNT;
          if (rx_sum_a_r == sum_a_r && rx_byte == sum_b_r) begin
            kind = ubxfr_pkg::KindGood;
          end else begin
            kind = ubxfr_pkg::KindBadSum;
          end
        end
        default: begin
          phase_nxt = ubxfr_pkg::PH_HUNT;
        end
      endcase
    end
    res.kind           = kind;
    res.class_code     = class_nxt;
    res.msg_id         = id_nxt;
    res.data_byte      = data_byte;
    res.byte_offset    = byte_offset;
    res.payload_length = length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ubxfr_pkg::PH_HUNT;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    class_r    <= class_nxt;
    id_r       <= id_nxt;
    length_r   <= length_nxt;
    count_r    <= count_nxt;
    sum_a_r    <= sum_a_nxt;
    sum_b_r    <= sum_b_nxt;
    rx_sum_a_r <= rx_sum_a_nxt;
  end

endmodule

>>> rtl/core/ubxfr_obuf.sv
// ----------------------------------------------------------------------------
// ubxfr_obuf
// Output register with one skid entry; lets the parser take a byte while a
// result waits downstream.
// ----------------------------------------------------------------------------
module ubxfr_obuf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  ubxfr_pkg::ubxfr_result_t push_res,
  output logic                     space_ok,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ubxfr_pkg::ubxfr_result_t out_res
);

  logic                     out_valid_r, out_valid_nxt;
  logic                     sk_valid_r, sk_valid_nxt;
  ubxfr_pkg::ubxfr_result_t out_res_r, out_res_nxt;
  ubxfr_pkg::ubxfr_result_t sk_res_r, sk_res_nxt;

  assign space_ok  = !sk_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sk_valid_nxt  = sk_valid_r;
    out_res_nxt   = out_res_r;
    sk_res_nxt    = sk_res_r;
    if (!out_valid_r || out_ready) begin
      if (sk_valid_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = sk_res_r;
        sk_valid_nxt  = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      sk_valid_nxt = 1'b1;
      sk_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    sk_res_r  <= sk_res_nxt;
  end

endmodule

>>> rtl/core/ubx_frame_receiver.sv
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// Streaming UBX frame receiver with Fletcher-8 checksum verdict.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the skid entry is free and gives
// at most one result beat per byte; each result beat is registered in the
// output buffer before it is offered. Payload bytes come out tagged with
// class, id and offset; a good or bad checksum verdict follows the second
// checksum byte; a length above BUFFER_BYTES - 8 gives a too-long beat and
// the parser hunts for sync again. The parser state advances once per
// accepted byte; a two-entry output buffer (output register and skid entry)
// keeps the byte stream flowing while the skid entry is free, and a stall
// that fills it holds off new bytes until the buffer drains.
module ubx_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  ubxfr_in_if.sink   in_bus,
  ubxfr_out_if.source out_bus
);

  logic                     beat_acc;
  logic                     space_ok;
  logic                     res_valid;
  ubxfr_pkg::ubxfr_result_t res;
  ubxfr_pkg::ubxfr_result_t out_res;

  assign in_bus.ready = space_ok;
  assign beat_acc     = in_bus.valid && space_ok;

  ubxfr_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_acc (beat_acc),
    .rx_byte  (in_bus.rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  ubxfr_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_res (res),
    .space_ok (space_ok),
    .out_valid(out_bus.valid),
    .out_ready(out_bus.ready),
    .out_res  (out_res)
  );

  assign out_bus.kind           = out_res.kind;
  assign out_bus.class_code     = out_res.class_code;
  assign out_bus.msg_id         = out_res.msg_id;
  assign out_bus.data_byte      = out_res.data_byte;
  assign out_bus.byte_offset    = out_res.byte_offset;
  assign out_bus.payload_length = out_res.payload_length;

endmodule

>>> rtl/core/ubxfr_checker.sv
// ----------------------------------------------------------------------------
// ubxfr_checker
// Port-level assertions for the UBX frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ubxfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_class_code,
  input logic [7:0]  out_msg_id,
  input logic [7:0]  out_data_byte,
  input logic [8:0]  out_byte_offset,
  input logic [15:0] out_payload_length
);

  // a new result beat is always caused by a byte beat
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result beat appeared without a byte beat");

  // bytes are held off only behind a stalled result
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("byte channel stalled without downstream stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_kind, out_class_code, out_msg_id, out_data_byte,
               out_byte_offset, out_payload_length}))
    else $error("stalled result beat changed");

  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != ubxfr_pkg::KindData |->
      out_data_byte == 8'h00 && out_byte_offset == 9'd0)
    else $error("verdict beat carries data or offset");

endmodule

bind ubx_frame_receiver ubxfr_checker u_ubxfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_kind          (out_bus.kind),
  .out_class_code    (out_bus.class_code),
  .out_msg_id        (out_bus.msg_id),
  .out_data_byte     (out_bus.data_byte),
  .out_byte_offset   (out_bus.byte_offset),
  .out_payload_length(out_bus.payload_length)
);
